// ===== design/prdf_pkg.sv =====
// Package for the proportional row duplicate finder: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package prdf_pkg;
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 256;
	localparam int VALUE_BITS = 32;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int NROW_W = ROW_W + 1;
	localparam int NCOL_W = COL_W + 1;
	localparam int TOL_W = 31;
	localparam int CFG_W = 31;
	localparam int QDIV_W = 49;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_SKIP = 2'd1,
		ACT_SEARCH = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_TOL = 2'd2
	} reg_idx_t;

	// search sequencer states
	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_ROW, ST_RD, ST_WAIT, ST_EVAL, ST_DIV, ST_CMP, ST_EMIT, ST_FIN
	} search_state_t;

	// divider start/finish handshake
	typedef struct packed {
		logic start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] quo;
	} div_rsp_t;
endpackage

// ===== design/prdf_div.sv =====
// Serial signed divider: saturated Q16.16 quotient (a*65536)/b, one bit a cycle.
// Depends on prdf_pkg.
`timescale 1ns / 1ps
module prdf_div (
	input logic clk,
	input logic arst_n,
	input prdf_pkg::div_req_t req,
	output prdf_pkg::div_rsp_t rsp
);
	import prdf_pkg::*;

	logic busy_q;
	logic [5:0] cnt_q;
	logic [QDIV_W-1:0] rem_q;
	logic [QDIV_W-1:0] quo_q;
	logic [QDIV_W-1:0] num_q;
	logic [31:0] den_q;
	logic neg_q;
	logic done_q;
	logic [QDIV_W:0] trial;
	logic [QDIV_W-1:0] rem_sh;
	logic [QDIV_W-1:0] quo_n;
	logic [QDIV_W:0] sq;

	// magnitudes of numerator and denominator; the numerator is scaled by 2^16 on start
	logic [31:0] an, bn;
	assign an = req.num[31] ? 32'(-req.num) : 32'(req.num);
	assign bn = req.den[31] ? 32'(-req.den) : 32'(req.den);

	assign rem_sh = {rem_q[QDIV_W-2:0], num_q[QDIV_W-1]};
	assign trial = {1'b0, rem_sh} - {{(QDIV_W-31){1'b0}}, den_q};
	assign quo_n = {quo_q[QDIV_W-2:0], ~trial[QDIV_W]};

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(QDIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= {1'b0, an, 16'd0};
			den_q <= bn;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			rem_q <= trial[QDIV_W] ? rem_sh : trial[QDIV_W-1:0];
			quo_q <= quo_n;
			num_q <= {num_q[QDIV_W-2:0], 1'b0};
		end
	end

	// sign and saturate
	always_comb begin
		sq = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		rsp.done = done_q;
		if (!neg_q && quo_q > QDIV_W'(32'h7fffffff))
			rsp.quo = 32'sh7fffffff;
		else if (neg_q && quo_q > QDIV_W'(33'h80000000))
			rsp.quo = 32'sh80000000;
		else
			rsp.quo = sq[31:0];
	end
endmodule

// ===== design/proportional_row_duplicate_finder.sv =====
// Proportional row duplicate finder top level: matrix memory, skip mask, search sequencer.
// Depends on prdf_pkg and prdf_div.
// Operation: load and skip words are written when accepted. A search visits each later row;
// per column it reads the base and then the partner value, passes over skipped columns and
// columns zero in both rows, and runs the rest through the 49-step serial divider; each
// match then waits for the output register. Input takes one word at a time and is held
// off while a search runs. Reset: registers return to defaults; a pass clears the skip mask
// entry by entry with in_ready low; matrix memory is not cleared.
`timescale 1ns / 1ps
module proportional_row_duplicate_finder (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] action,
	input logic [5:0] row,
	input logic [7:0] column,
	input logic signed [31:0] value,
	input logic skip,
	output logic out_valid,
	input logic out_ready,
	output logic [5:0] base_row,
	output logic [5:0] partner_row,
	output logic found,
	output logic last,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_data
);
	import prdf_pkg::*;

	search_state_t st_q, st_d;
	logic [NROW_W-1:0] rows_q;
	logic [NCOL_W-1:0] cols_q;
	logic [TOL_W-1:0] tol_q;

	logic signed [31:0] mem [0:MAX_ROWS*MAX_COLS-1];
	logic skip_mem [0:MAX_COLS-1];
	logic signed [31:0] rd_s1;
	logic skip_s1;
	logic [ADDR_W-1:0] rd_addr;
	logic rd_en;
	logic [COL_W-1:0] clr_q;

	logic [ROW_W-1:0] base_q;
	logic [NROW_W-1:0] part_q;
	logic [NCOL_W-1:0] col_q;
	logic phase_q;
	logic signed [31:0] a_q, b_q;
	logic have_ref_q;
	logic signed [31:0] ref_q;
	logic pend_q;
	logic [ROW_W-1:0] pend_part_q;
	logic ob_valid_q, ob_found_q, ob_last_q;
	logic [5:0] ob_base_q, ob_part_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [NROW_W-1:0] nrows;
	logic [NCOL_W-1:0] ncols;
	logic [32:0] dev;
	logic [32:0] dabs;
	logic row_end, tol_fail, in_acc;

	prdf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign nrows = (rows_q > NROW_W'(MAX_ROWS)) ? NROW_W'(MAX_ROWS) : rows_q;
	assign ncols = (cols_q > NCOL_W'(MAX_COLS)) ? NCOL_W'(MAX_COLS) : cols_q;
	assign in_ready = (st_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = ob_valid_q;
	assign base_row = ob_base_q;
	assign partner_row = ob_part_q;
	assign found = ob_found_q;
	assign last = ob_last_q;
	assign dev = {ref_q[31], ref_q} - {drsp.quo[31], drsp.quo};
	assign dabs = dev[32] ? -dev : dev;
	assign tol_fail = (dabs > {2'b0, tol_q});
	assign row_end = (col_q >= ncols);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= NROW_W'(64);
			cols_q <= NCOL_W'(256);
			tol_q <= TOL_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROWS: rows_q <= cfg_data[NROW_W-1:0];
				REG_COLS: cols_q <= cfg_data[NCOL_W-1:0];
				REG_TOL: tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// skip mask memory: cleared entry by entry after reset, registered read
	always_ff @(posedge clk) begin
		if (st_q == ST_CLR)
			skip_mem[clr_q] <= 1'b0;
		else if (in_acc && action_t'(action) == ACT_SKIP)
			skip_mem[column] <= skip;
		if (rd_en)
			skip_s1 <= skip_mem[col_q[COL_W-1:0]];
	end

	// matrix memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (in_acc && action_t'(action) == ACT_LOAD)
			mem[{row, column}] <= value;
		if (rd_en)
			rd_s1 <= mem[rd_addr];
	end

	// read address: base row on phase 0, partner row on phase 1
	always_comb begin
		rd_en = (st_q == ST_RD);
		rd_addr = {phase_q ? part_q[ROW_W-1:0] : base_q, col_q[COL_W-1:0]};
	end

	always_comb begin
		st_d = st_q;
		dreq.start = 1'b0;
		dreq.num = a_q;
		dreq.den = b_q;
		unique case (st_q)
			ST_CLR: if (clr_q == COL_W'(MAX_COLS - 1)) st_d = ST_IDLE;
			ST_IDLE: if (in_acc && action_t'(action) == ACT_SEARCH)
				st_d = ST_ROW;
			ST_ROW: st_d = (part_q >= nrows) ? ST_FIN : ST_RD;
			ST_RD: st_d = row_end ? ST_EMIT : ST_WAIT;
			ST_WAIT: begin
				if (skip_s1 || !phase_q) st_d = ST_RD;
				else st_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (a_q == '0 && b_q == '0) st_d = ST_RD;
				else if (b_q == '0 || (!have_ref_q && a_q == '0)) st_d = ST_ROW;
				else begin
					dreq.start = 1'b1;
					st_d = ST_DIV;
				end
			end
			ST_DIV: if (drsp.done) st_d = ST_CMP;
			ST_CMP: st_d = (have_ref_q && tol_fail) ? ST_ROW : ST_RD;
			ST_EMIT: if (!pend_q || !ob_valid_q) st_d = ST_ROW;
			ST_FIN: if (!ob_valid_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_CLR;
		else st_q <= st_d;
	end

	// search bookkeeping; a match is held back until the next one or the end sets last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			base_q <= '0;
			part_q <= '0;
			col_q <= '0;
			phase_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			have_ref_q <= 1'b0;
			ref_q <= '0;
			pend_q <= 1'b0;
			pend_part_q <= '0;
			ob_valid_q <= 1'b0;
			ob_found_q <= 1'b0;
			ob_last_q <= 1'b0;
			ob_base_q <= '0;
			ob_part_q <= '0;
		end else begin
			if (ob_valid_q && out_ready) ob_valid_q <= 1'b0;
			unique case (st_q)
				ST_CLR: clr_q <= clr_q + COL_W'(1);
				ST_IDLE: if (in_acc && action_t'(action) == ACT_SEARCH) begin
					base_q <= row;
					part_q <= (NROW_W'(row) >= nrows) ? NROW_W'(MAX_ROWS)
						: NROW_W'(row) + NROW_W'(1);
					pend_q <= 1'b0;
				end
				ST_ROW: begin
					col_q <= '0;
					phase_q <= 1'b0;
					have_ref_q <= 1'b0;
				end
				ST_WAIT: begin
					if (skip_s1) col_q <= col_q + NCOL_W'(1);
					else begin
						if (phase_q) b_q <= rd_s1;
						else a_q <= rd_s1;
						phase_q <= ~phase_q;
					end
				end
				ST_EVAL: begin
					if (a_q == '0 && b_q == '0) col_q <= col_q + NCOL_W'(1);
					else if (b_q == '0 || (!have_ref_q && a_q == '0))
						part_q <= part_q + NROW_W'(1);
				end
				ST_CMP: begin
					if (have_ref_q && tol_fail)
						part_q <= part_q + NROW_W'(1);
					else begin
						col_q <= col_q + NCOL_W'(1);
						if (!have_ref_q) begin
							ref_q <= drsp.quo;
							have_ref_q <= 1'b1;
						end
					end
				end
				ST_EMIT: if (!pend_q || !ob_valid_q) begin
					if (pend_q) begin
						ob_valid_q <= 1'b1;
						ob_base_q <= base_q;
						ob_part_q <= pend_part_q;
						ob_found_q <= 1'b1;
						ob_last_q <= 1'b0;
					end
					pend_q <= 1'b1;
					pend_part_q <= part_q[ROW_W-1:0];
					part_q <= part_q + NROW_W'(1);
				end
				ST_FIN: if (!ob_valid_q) begin
					ob_valid_q <= 1'b1;
					ob_base_q <= base_q;
					ob_part_q <= pend_q ? pend_part_q : '0;
					ob_found_q <= pend_q;
					ob_last_q <= 1'b1;
					pend_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({base_row, partner_row, found, last}))
		else $error("result changed while waiting");
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !in_ready)
		else $error("ready while searching");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |=> st_q == ST_DIV)
		else $error("divider start without wait");
`endif
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for proportional_row_duplicate_finder.
// Depends on prdf_pkg and the design; holds its own row-ratio predictor and scoreboard.
`timescale 1ns / 1ps
module tb;
	import prdf_pkg::*;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [5:0] base;
		logic [5:0] partner;
		logic found;
		logic last;
	} match_t;

	// one directed stimulus row; chk marks a result typed in by hand
	typedef struct {
		logic [1:0] act;
		logic [5:0] r;
		logic [7:0] c;
		logic [31:0] v;
		logic s;
		bit chk;
		bit efound;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [5:0] row = '0;
	logic [7:0] column = '0;
	logic signed [31:0] value = '0;
	logic skip = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] base_row;
	logic [5:0] partner_row;
	logic found;
	logic last;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	// predictor state
	logic signed [31:0] mat [MAX_ROWS][MAX_COLS];
	bit skip_cols [MAX_COLS];
	int unsigned rows_cfg, cols_cfg, tol_cfg;
	match_t match_q [$];

	int errors = 0;
	int mismatches = 0;
	int n_words = 0;
	int n_searches = 0;
	int n_matches = 0;
	int cycles = 0;
	bit burst = 0;
	logic signed [31:0] proto [8];

	proportional_row_duplicate_finder u_top (.*);

	always #4 clk = ~clk;

	// Q16.16 quotient with saturation
	function automatic longint ratio_q(longint a, longint b);
		longint q;
		q = (a * 65536) / b;
		if (q > SAT_HI) return SAT_HI;
		if (q < SAT_LO) return SAT_LO;
		return q;
	endfunction

	function automatic bit rows_proportional(int r1, int r2);
		int nc;
		bit have_ref;
		longint rref, a, b, d;
		nc = cols_cfg > MAX_COLS ? MAX_COLS : cols_cfg;
		have_ref = 0;
		rref = 0;
		for (int c = 0; c < nc; c++) begin
			if (skip_cols[c]) continue;
			a = mat[r1][c];
			b = mat[r2][c];
			if (a == 0 && b == 0) continue;
			if (!have_ref) begin
				if (a == 0 || b == 0) return 0;
				rref = ratio_q(a, b);
				have_ref = 1;
				continue;
			end
			if (b == 0) return 0;
			d = ratio_q(a, b) - rref;
			if (d < 0) d = -d;
			if (d > longint'(tol_cfg)) return 0;
		end
		return 1;
	endfunction

	// apply one accepted word to the predictor, queue the matches it causes
	task automatic predict_word(logic [1:0] a, logic [5:0] r, logic [7:0] c,
			logic [31:0] v, logic s);
		int nr;
		int cnt;
		match_t m;
		nr = rows_cfg > MAX_ROWS ? MAX_ROWS : rows_cfg;
		cnt = 0;
		case (a)
			ACT_LOAD: mat[r][c] = v;
			ACT_SKIP: skip_cols[c] = s;
			ACT_SEARCH: begin
				n_searches++;
				if (r < nr) begin
					for (int p = r + 1; p < nr; p++) begin
						if (rows_proportional(r, p)) begin
							m = '{base: r, partner: p[5:0], found: 1'b1, last: 1'b0};
							match_q.push_back(m);
							cnt++;
						end
					end
				end
				if (cnt == 0) begin
					m = '{base: r, partner: 6'd0, found: 1'b0, last: 1'b1};
					match_q.push_back(m);
				end else match_q[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	// drive one word on the input channel and wait for acceptance
	task automatic send_word(logic [1:0] a, logic [5:0] r, logic [7:0] c,
			logic [31:0] v, logic s);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = a;
		row = r;
		column = c;
		value = v;
		skip = s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_word(a, r, c, v, s);
		n_words++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// registers change only with the block idle
	task automatic write_reg(reg_idx_t idx, int unsigned data);
		wait (match_q.size() == 0);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data[30:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_ROWS: rows_cfg = data & 32'h7F;
			REG_COLS: cols_cfg = data & 32'h1FF;
			REG_TOL: tol_cfg = data & 32'h7FFF_FFFF;
			default: ;
		endcase
	endtask

	task automatic set_regs(int unsigned nr, int unsigned nc, int unsigned tol);
		write_reg(REG_ROWS, nr);
		write_reg(REG_COLS, nc);
		write_reg(REG_TOL, tol);
	endtask

	// load rows lo..hi, nc cols: scaled prototype copies, random rows, zero rows
	task automatic fill_rows(int lo, int hi, int nc);
		int kind;
		logic [31:0] v;
		for (int i = 0; i < 8; i++)
			proto[i] = ($urandom_range(0, 3) == 0) ? 0 : $signed($urandom_range(0, 2097152)) - 1048576;
		for (int r = lo; r <= hi; r++) begin
			kind = $urandom_range(0, 5);
			for (int c = 0; c < nc; c++) begin
				case (kind)
					0: v = proto[c % 8];
					1: v = proto[c % 8] <<< 1;
					2: v = proto[c % 8] * 3;
					3: v = $urandom;
					4: v = 0;
					default: v = proto[c % 8] + ((c == nc - 1) ? 1 : 0);
				endcase
				send_word(ACT_LOAD, 6'(r), 8'(c), v, 1'b0);
			end
		end
	endtask

	// result side: random stalls, check in the scoreboard
	initial begin
		int w;
		forever begin
			@(negedge clk);
			w = burst ? 0 : $urandom_range(0, 8);
			if (w > 0) begin
				out_ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		match_t exp_m;
		if (arst_n && out_valid && out_ready) begin
			n_matches++;
			if (match_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result base %0d partner %0d",
					base_row, partner_row);
			end else begin
				exp_m = match_q.pop_front();
				if (exp_m !== {base_row, partner_row, found, last}) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp base %0d partner %0d found %0d last %0d, got %0d %0d %0d %0d",
							exp_m.base, exp_m.partner, exp_m.found, exp_m.last,
							base_row, partner_row, found, last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		dir_row_t dir [$];
		int nr, nc, tol, pick;
		foreach (skip_cols[i]) skip_cols[i] = 0;
		rows_cfg = 64;
		cols_cfg = 256;
		tol_cfg = 1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: 4x4 matrix with a proportional pair and the value extremes
		set_regs(4, 4, 1);
		dir = '{
			'{ACT_LOAD, 0, 0, 32'h0001_0000, 0, 0, 0},
			'{ACT_LOAD, 0, 1, 32'h0002_0000, 0, 0, 0},
			'{ACT_LOAD, 0, 2, 32'h0000_0000, 0, 0, 0},
			'{ACT_LOAD, 0, 3, 32'hFFFF_0000, 0, 0, 0},
			'{ACT_LOAD, 1, 0, 32'h0002_0000, 0, 0, 0},
			'{ACT_LOAD, 1, 1, 32'h0004_0000, 0, 0, 0},
			'{ACT_LOAD, 1, 2, 32'h0000_0000, 0, 0, 0},
			'{ACT_LOAD, 1, 3, 32'hFFFE_0000, 0, 0, 0},
			'{ACT_LOAD, 2, 0, 32'h7FFF_FFFF, 0, 0, 0},
			'{ACT_LOAD, 2, 1, 32'h8000_0000, 0, 0, 0},
			'{ACT_LOAD, 2, 2, 32'h0000_0005, 0, 0, 0},
			'{ACT_LOAD, 2, 3, 32'h0000_0000, 0, 0, 0},
			'{ACT_LOAD, 3, 0, 32'h0000_0000, 0, 0, 0},
			'{ACT_LOAD, 3, 1, 32'h0000_0000, 0, 0, 0},
			'{ACT_LOAD, 3, 2, 32'h0000_0000, 0, 0, 0},
			'{ACT_LOAD, 3, 3, 32'h0000_0000, 0, 0, 0},
			'{ACT_SEARCH, 0, 0, 0, 0, 0, 0},
			'{ACT_SEARCH, 3, 0, 0, 0, 1, 0},   // last row: nothing later
			'{ACT_SEARCH, 63, 0, 0, 0, 1, 0},  // base beyond rows in use
			'{ACT_SKIP, 0, 0, 0, 1, 0, 0},
			'{ACT_SEARCH, 2, 0, 0, 0, 0, 0},
			'{2'd3, 63, 255, 32'hFFFF_FFFF, 1, 0, 0},  // unknown action, ignored
			'{ACT_SKIP, 0, 0, 0, 0, 0, 0},
			'{ACT_SEARCH, 1, 0, 0, 0, 0, 0}
		};
		foreach (dir[i]) begin
			send_word(dir[i].act, dir[i].r, dir[i].c, dir[i].v, dir[i].s);
			if (dir[i].chk && (match_q.size() == 0 || match_q[$].found !== dir[i].efound
					|| match_q[$].last !== 1'b1 || match_q[$].partner !== 6'd0)) begin
				errors++;
				$display("directed row %0d: predicted result disagrees with table", i);
			end
		end

		// register extremes: zero columns, too few rows, saturation
		set_regs(5, 0, 0);
		send_word(ACT_SEARCH, 6'd0, 8'd0, 32'd0, 1'b0);
		set_regs(1, 4, 0);
		send_word(ACT_SEARCH, 6'd0, 8'd0, 32'd0, 1'b0);
		set_regs(0, 4, 32'h7FFF_FFFF);
		send_word(ACT_SEARCH, 6'd0, 8'd0, 32'd0, 1'b0);
		set_regs(127, 511, 32'h7FFF_FFFF);
		send_word(ACT_SKIP, 6'd0, 8'd255, 32'd0, 1'b1);
		send_word(ACT_SEARCH, 6'd63, 8'd0, 32'd0, 1'b0);
		send_word(ACT_SKIP, 6'd0, 8'd255, 32'd0, 1'b0);

		// random phases over small matrices
		for (int ph = 0; ph < 4; ph++) begin
			burst = (ph == 2);
			nr = $urandom_range(2, 5);
			nc = $urandom_range(1, 4);
			case (ph)
				0: tol = 0;
				1: tol = 1;
				2: tol = $urandom_range(0, 65536);
				default: tol = 32'h7FFF_FFFF;
			endcase
			set_regs(nr, nc, tol);
			fill_rows(0, nr - 1, nc);
			repeat (8) begin
				pick = $urandom_range(0, 19);
				if (pick < 10)
					send_word(ACT_SEARCH, 6'($urandom_range(0, nr + 1)), 8'($urandom),
						$urandom, 1'($urandom));
				else if (pick < 15)
					send_word(ACT_LOAD, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
						$urandom, 1'($urandom));
				else if (pick < 19)
					send_word(ACT_SKIP, 6'($urandom), 8'($urandom_range(0, nc)), $urandom,
						1'($urandom));
				else
					send_word(2'd3, 6'($urandom), 8'($urandom), $urandom, 1'($urandom));
			end
		end
		burst = 0;

		wait (match_q.size() == 0);
		repeat (200) @(negedge clk);
		$display("Sent %0d words including %0d searches; checked %0d results.",
			n_words, n_searches, n_matches);
		$display("Covered register extremes, skipped columns, value extremes and random stalls.");
		if (errors == 0 && match_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/prdf_pkg.sv
design/prdf_div.sv
design/proportional_row_duplicate_finder.sv
tb/tb.sv
